### rtl/position_pid_controller_defines.svh
// Assertion macros for the position PID controller.
`ifndef POSITION_PID_CONTROLLER_DEFINES_SVH
`define POSITION_PID_CONTROLLER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PPC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("position_pid_controller: same-cycle check failed");
`define PPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("position_pid_controller: next-cycle check failed");
`else
`define PPC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define PPC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/ppc_pkg.sv
package ppc_pkg;

  localparam int DATA_W   = 32;
  localparam int LIM_W    = 31;
  localparam int TORQUE_W = 16;
  localparam int CFG_AW   = 3;

  localparam int FRAC_BITS = 16;
  localparam longint ONE_Q = longint'(1) << FRAC_BITS;

  localparam int MUL_W = DATA_W + 1;
  localparam int CNT_W = $clog2(MUL_W);
  localparam int ACC_W = 2 * MUL_W;

  localparam logic [MUL_W-1:0] LAMBDA_B = MUL_W'((ONE_Q * 5 + 50) / 100);
  localparam logic [MUL_W-1:0] KEEP_B   = MUL_W'(ONE_Q - (ONE_Q * 5 + 50) / 100);

  localparam logic [CFG_AW-1:0] REG_ENC_OFFSET = 3'd0;
  localparam logic [CFG_AW-1:0] REG_POS_SCALE  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_POS_OFFSET = 3'd2;
  localparam logic [CFG_AW-1:0] REG_P_GAIN     = 3'd3;
  localparam logic [CFG_AW-1:0] REG_D_GAIN     = 3'd4;
  localparam logic [CFG_AW-1:0] REG_I_GAIN     = 3'd5;
  localparam logic [CFG_AW-1:0] REG_INT_LIMIT  = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_POS,
    ST_ERR,
    ST_RAW,
    ST_FILT,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_POS,
    OP_FILT_A,
    OP_FILT_B,
    OP_P,
    OP_D,
    OP_I
  } op_t;

  function automatic logic signed [MUL_W-1:0] sext_mul(input logic signed [DATA_W-1:0] v);
    return {v[DATA_W-1], v};
  endfunction

  function automatic logic signed [ACC_W-1:0] sext_acc(input logic signed [DATA_W-1:0] v);
    return {{(ACC_W-DATA_W){v[DATA_W-1]}}, v};
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [ACC_W-1:0] v);
    logic fits;
    fits = (&v[ACC_W-1:DATA_W-1]) | ~(|v[ACC_W-1:DATA_W-1]);
    if (fits) begin
      return v[DATA_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [TORQUE_W-1:0] sat_torque(input logic signed [ACC_W-1:0] v);
    logic fits;
    fits = (&v[ACC_W-1:TORQUE_W-1]) | ~(|v[ACC_W-1:TORQUE_W-1]);
    if (fits) begin
      return v[TORQUE_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(TORQUE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(TORQUE_W-1){1'b1}}};
    end
  endfunction

endpackage

### rtl/position_pid_controller.sv
// Position PID controller with a low-pass filtered derivative and a clamped integral. Each
// request carries an encoder count, a target position and a feedforward term, and yields one
// torque setpoint together with the position error of that tick. All six products of a tick
// (position scaling, the two filter taps and the three gains) are formed one after another in a
// single shared shift-and-add multiplier that retires one multiplier bit per clock. A new request
// is taken only once the block is idle again, after the result of the last one has moved into the
// output register. A result waiting in the output register does not hold off the next request.
// Configuration registers are written through the plain write port; the user must write them only
// while no request is in flight, as the block itself does not enforce this.
`include "position_pid_controller_defines.svh"

module position_pid_controller (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [ppc_pkg::DATA_W-1:0]      in_encoder_count,
  input  logic signed [ppc_pkg::DATA_W-1:0]      in_target_position,
  input  logic signed [ppc_pkg::DATA_W-1:0]      in_feedforward,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [ppc_pkg::TORQUE_W-1:0]    out_torque_setpoint,
  output logic signed [ppc_pkg::DATA_W-1:0]      out_position_error,
  input  logic                                   cfg_wr_en,
  input  logic [ppc_pkg::CFG_AW-1:0]             cfg_addr,
  input  logic [ppc_pkg::DATA_W-1:0]             cfg_wdata
);
  import ppc_pkg::*;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic signed [MUL_W:0]   hi_r, hi_nxt;
  logic [MUL_W-1:0]        lo_r, lo_nxt;
  logic signed [MUL_W-1:0] mcand_r, mcand_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;

  logic signed [DATA_W-1:0] tgt_r, tgt_nxt;
  logic signed [DATA_W-1:0] ff_r, ff_nxt;
  logic signed [DATA_W-1:0] pos_r, pos_nxt;
  logic signed [DATA_W-1:0] err_r, err_nxt;

  logic signed [DATA_W-1:0] prev_r, prev_nxt;
  logic signed [DATA_W-1:0] filt_r, filt_nxt;
  logic signed [DATA_W-1:0] integ_r, integ_nxt;

  logic signed [DATA_W-1:0] enc_off_r, enc_off_nxt;
  logic signed [DATA_W-1:0] pos_scale_r, pos_scale_nxt;
  logic signed [DATA_W-1:0] pos_off_r, pos_off_nxt;
  logic signed [DATA_W-1:0] p_gain_r, p_gain_nxt;
  logic signed [DATA_W-1:0] d_gain_r, d_gain_nxt;
  logic signed [DATA_W-1:0] i_gain_r, i_gain_nxt;
  logic [LIM_W-1:0]         int_lim_r, int_lim_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic signed [TORQUE_W-1:0] out_torque_r, out_torque_nxt;
  logic signed [DATA_W-1:0]   out_err_r, out_err_nxt;

  logic                    in_take;
  logic                    out_free;
  logic                    mul_last;
  logic signed [MUL_W:0]   mcand_ext;
  logic signed [MUL_W:0]   addend;
  logic signed [MUL_W:0]   mul_sum;
  logic signed [ACC_W-1:0] prod;
  logic signed [ACC_W-1:0] acc_sum;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] pos_wide;
  logic signed [ACC_W-1:0] err_wide;
  logic signed [ACC_W-1:0] torque_wide;
  logic                    round_up;
  logic signed [MUL_W-1:0] integ_sum;
  logic signed [MUL_W-1:0] lim_ext;
  logic signed [MUL_W-1:0] neg_lim;

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign mul_last  = (cnt_r == CNT_W'(MUL_W - 1));
  assign mcand_ext = {mcand_r[MUL_W-1], mcand_r};
  assign addend    = lo_r[0] ? (mul_last ? -mcand_ext : mcand_ext) : '0;
  assign mul_sum   = hi_r + addend;
  assign prod      = {hi_r[MUL_W-1:0], lo_r};
  assign acc_sum   = acc_r + prod;

  assign acc_q       = acc_r >>> FRAC_BITS;
  assign pos_wide    = acc_q + sext_acc(pos_off_r);
  assign err_wide    = sext_acc(tgt_r) - sext_acc(pos_r);
  assign round_up    = acc_r[ACC_W-1] && (|acc_r[FRAC_BITS-1:0]);
  assign torque_wide = acc_q + {{(ACC_W-1){1'b0}}, round_up};

  assign integ_sum = sext_mul(integ_r) + sext_mul(err_r);
  assign lim_ext   = {2'b00, int_lim_r};
  assign neg_lim   = -lim_ext;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    cnt_nxt        = cnt_r;
    hi_nxt         = hi_r;
    lo_nxt         = lo_r;
    mcand_nxt      = mcand_r;
    acc_nxt        = acc_r;
    tgt_nxt        = tgt_r;
    ff_nxt         = ff_r;
    pos_nxt        = pos_r;
    err_nxt        = err_r;
    prev_nxt       = prev_r;
    filt_nxt       = filt_r;
    integ_nxt      = integ_r;
    enc_off_nxt    = enc_off_r;
    pos_scale_nxt  = pos_scale_r;
    pos_off_nxt    = pos_off_r;
    p_gain_nxt     = p_gain_r;
    d_gain_nxt     = d_gain_r;
    i_gain_nxt     = i_gain_r;
    int_lim_nxt    = int_lim_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_torque_nxt = out_torque_r;
    out_err_nxt    = out_err_r;

    if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_ENC_OFFSET: enc_off_nxt   = cfg_wdata;
        REG_POS_SCALE:  pos_scale_nxt = cfg_wdata;
        REG_POS_OFFSET: pos_off_nxt   = cfg_wdata;
        REG_P_GAIN:     p_gain_nxt    = cfg_wdata;
        REG_D_GAIN:     d_gain_nxt    = cfg_wdata;
        REG_I_GAIN:     i_gain_nxt    = cfg_wdata;
        REG_INT_LIMIT:  int_lim_nxt   = cfg_wdata[LIM_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          tgt_nxt   = in_target_position;
          ff_nxt    = in_feedforward;
          acc_nxt   = '0;
          mcand_nxt = sext_mul(in_encoder_count) - sext_mul(enc_off_r);
          lo_nxt    = sext_mul(pos_scale_r);
          hi_nxt    = '0;
          cnt_nxt   = '0;
          op_nxt    = OP_POS;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        hi_nxt  = {mul_sum[MUL_W], mul_sum[MUL_W:1]};
        lo_nxt  = {mul_sum[0], lo_r[MUL_W-1:1]};
        cnt_nxt = cnt_r + 1'b1;
        if (mul_last) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        acc_nxt = acc_sum;
        hi_nxt  = '0;
        cnt_nxt = '0;
        unique case (op_r)
          OP_POS:    state_nxt = ST_POS;
          OP_FILT_A: begin
            mcand_nxt = sext_mul(filt_r);
            lo_nxt    = KEEP_B;
            op_nxt    = OP_FILT_B;
            state_nxt = ST_MUL;
          end
          OP_FILT_B: state_nxt = ST_FILT;
          OP_P: begin
            mcand_nxt = sext_mul(filt_r);
            lo_nxt    = sext_mul(d_gain_r);
            op_nxt    = OP_D;
            state_nxt = ST_MUL;
          end
          OP_D: begin
            mcand_nxt = sext_mul(integ_r);
            lo_nxt    = sext_mul(i_gain_r);
            op_nxt    = OP_I;
            state_nxt = ST_MUL;
          end
          OP_I:      state_nxt = ST_DONE;
          default:   state_nxt = ST_IDLE;
        endcase
      end
      ST_POS: begin
        pos_nxt   = sat_data(pos_wide);
        state_nxt = ST_ERR;
      end
      ST_ERR: begin
        err_nxt   = sat_data(err_wide);
        state_nxt = ST_RAW;
      end
      ST_RAW: begin
        prev_nxt = err_r;
        if (integ_sum > lim_ext) begin
          integ_nxt = lim_ext[DATA_W-1:0];
        end else if (integ_sum < neg_lim) begin
          integ_nxt = neg_lim[DATA_W-1:0];
        end else begin
          integ_nxt = integ_sum[DATA_W-1:0];
        end
        acc_nxt   = '0;
        mcand_nxt = sext_mul(err_r) - sext_mul(prev_r);
        lo_nxt    = LAMBDA_B;
        hi_nxt    = '0;
        cnt_nxt   = '0;
        op_nxt    = OP_FILT_A;
        state_nxt = ST_MUL;
      end
      ST_FILT: begin
        filt_nxt  = sat_data(acc_q);
        acc_nxt   = sext_acc(ff_r);
        mcand_nxt = sext_mul(err_r);
        lo_nxt    = sext_mul(p_gain_r);
        hi_nxt    = '0;
        cnt_nxt   = '0;
        op_nxt    = OP_P;
        state_nxt = ST_MUL;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_torque_nxt = sat_torque(torque_wide);
          out_err_nxt    = err_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_POS;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      prev_r      <= '0;
      filt_r      <= '0;
      integ_r     <= '0;
      enc_off_r   <= '0;
      pos_scale_r <= '0;
      pos_off_r   <= '0;
      p_gain_r    <= '0;
      d_gain_r    <= '0;
      i_gain_r    <= '0;
      int_lim_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      prev_r      <= prev_nxt;
      filt_r      <= filt_nxt;
      integ_r     <= integ_nxt;
      enc_off_r   <= enc_off_nxt;
      pos_scale_r <= pos_scale_nxt;
      pos_off_r   <= pos_off_nxt;
      p_gain_r    <= p_gain_nxt;
      d_gain_r    <= d_gain_nxt;
      i_gain_r    <= i_gain_nxt;
      int_lim_r   <= int_lim_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r         <= hi_nxt;
    lo_r         <= lo_nxt;
    mcand_r      <= mcand_nxt;
    acc_r        <= acc_nxt;
    tgt_r        <= tgt_nxt;
    ff_r         <= ff_nxt;
    pos_r        <= pos_nxt;
    err_r        <= err_nxt;
    out_torque_r <= out_torque_nxt;
    out_err_r    <= out_err_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_torque_setpoint = out_torque_r;
  assign out_position_error  = out_err_r;

  `PPC_ASSERT_NEXT(a_start_scaling, clk, rst_n, in_take, (state_r == ST_MUL) && (op_r == OP_POS) && (cnt_r == '0))
  `PPC_ASSERT_NEXT(a_integral_clamped, clk, rst_n, state_r == ST_RAW, (sext_mul(integ_r) <= lim_ext) && (sext_mul(integ_r) >= neg_lim))
  `PPC_ASSERT_IMPLY(a_result_from_done, clk, rst_n, $rose(out_valid_r), $past(state_r) == ST_DONE)
  `PPC_ASSERT_IMPLY(a_idle_only_between, clk, rst_n, (state_r == ST_MUL) && (op_r == OP_I) && mul_last, !in_take)

endmodule
